### hw/rtl/zzsag_pkg.sv
// Shared constants and types for the zigzag scan address generator.
`default_nettype none

package zzsag_pkg;

  // Configuration register file.
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  // Largest rectangle side the generator supports.
  localparam int unsigned MAX_DIM_DEFAULT = 64;

  // Stream payload widths that do not depend on the rectangle size.
  localparam int unsigned IN_TDATA_W = 8;

endpackage

`default_nettype wire

### hw/rtl/zzsag_cfg.sv
// Configuration registers for the rectangle size, with range clamping.
`default_nettype none

module zzsag_cfg #(
  parameter int unsigned MAX_DIM = zzsag_pkg::MAX_DIM_DEFAULT,
  localparam int unsigned DimW   = $clog2(MAX_DIM + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [zzsag_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [zzsag_pkg::CFG_W-1:0]      cfg_data_i,
  output logic      [DimW-1:0]                  rows_o,
  output logic      [DimW-1:0]                  cols_o
);
  import zzsag_pkg::*;

  localparam int unsigned CmpW = (CFG_W > DimW) ? CFG_W : DimW;
  localparam logic [CmpW-1:0] DimMax = CmpW'(MAX_DIM);

  logic [CFG_W-1:0] row_count_q, row_count_d;
  logic [CFG_W-1:0] col_count_q, col_count_d;

  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROW_COUNT: row_count_d = cfg_data_i;
        REG_COL_COUNT: col_count_d = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= DIM_RESET;
      col_count_q <= DIM_RESET;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
    end
  end

  // A zero size acts as one, a size beyond the maximum acts as the maximum.
  function automatic logic [DimW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CmpW-1:0] vx;
    vx = CmpW'(v);
    if (vx == '0) begin
      clamp_dim = DimW'(1);
    end else if (vx > DimMax) begin
      clamp_dim = DimW'(MAX_DIM);
    end else begin
      clamp_dim = DimW'(vx);
    end
  endfunction

  assign rows_o = clamp_dim(row_count_q);
  assign cols_o = clamp_dim(col_count_q);

endmodule

`default_nettype wire

### hw/rtl/zzsag_step.sv
// Next-cell logic of the zigzag walk: one step along or between diagonals, or back to (0,0).
`default_nettype none

module zzsag_step #(
  parameter int unsigned MAX_DIM = zzsag_pkg::MAX_DIM_DEFAULT,
  localparam int unsigned IdxW   = $clog2(MAX_DIM),
  localparam int unsigned DimW   = $clog2(MAX_DIM + 1),
  localparam int unsigned CntW   = 2 * IdxW + 1
) (
  input  wire logic [IdxW-1:0] cur_row_i,
  input  wire logic [IdxW-1:0] cur_col_i,
  input  wire logic [CntW-1:0] cur_cnt_i,
  input  wire logic            started_i,
  input  wire logic            restart_i,
  input  wire logic [DimW-1:0] rows_i,
  input  wire logic [DimW-1:0] cols_i,
  output logic      [IdxW-1:0] nxt_row_o,
  output logic      [IdxW-1:0] nxt_col_o,
  output logic      [CntW-1:0] nxt_cnt_o,
  output logic                 nxt_last_o
);
  localparam int unsigned XW = DimW + 1;

  logic [XW-1:0] r_x, c_x, r1_x, c1_x, rows_x, cols_x;
  logic [XW-1:0] nr1_x, nc1_x;
  logic          outside, was_last, to_first, odd_diag;

  assign r_x    = XW'(cur_row_i);
  assign c_x    = XW'(cur_col_i);
  assign r1_x   = r_x + XW'(1);
  assign c1_x   = c_x + XW'(1);
  assign rows_x = XW'(rows_i);
  assign cols_x = XW'(cols_i);

  assign outside  = (r_x >= rows_x) || (c_x >= cols_x);
  assign was_last = (r1_x == rows_x) && (c1_x == cols_x);
  assign to_first = restart_i || !started_i || outside || was_last;
  assign odd_diag = cur_row_i[0] ^ cur_col_i[0];

  always_comb begin
    nxt_row_o = cur_row_i;
    nxt_col_o = cur_col_i;
    nxt_cnt_o = cur_cnt_i + CntW'(1);
    if (to_first) begin
      nxt_row_o = '0;
      nxt_col_o = '0;
      nxt_cnt_o = CntW'(1);
    end else if (odd_diag) begin
      // Row falls along the diagonal; at the top or right edge move on.
      if ((cur_row_i != '0) && (c1_x < cols_x)) begin
        nxt_row_o = cur_row_i - IdxW'(1);
        nxt_col_o = cur_col_i + IdxW'(1);
      end else if (c1_x < cols_x) begin
        nxt_col_o = cur_col_i + IdxW'(1);
      end else begin
        nxt_row_o = cur_row_i + IdxW'(1);
      end
    end else begin
      // Row rises along the diagonal; at the left or bottom edge move on.
      if ((r1_x < rows_x) && (cur_col_i != '0)) begin
        nxt_row_o = cur_row_i + IdxW'(1);
        nxt_col_o = cur_col_i - IdxW'(1);
      end else if (r1_x < rows_x) begin
        nxt_row_o = cur_row_i + IdxW'(1);
      end else begin
        nxt_col_o = cur_col_i + IdxW'(1);
      end
    end
  end

  assign nr1_x      = XW'(nxt_row_o) + XW'(1);
  assign nc1_x      = XW'(nxt_col_o) + XW'(1);
  assign nxt_last_o = (nr1_x == rows_x) && (nc1_x == cols_x);

endmodule

`default_nettype wire

### hw/rtl/zigzag_scan_address_gen.sv
// Top level of the zigzag scan address generator.
// Usage:
//   Each transfer on the slave stream is one command: restart (tdata bit 0)
//   set returns to cell (0,0) with order 1, clear advances to the next cell.
//   Every command yields exactly one transfer on the master stream carrying
//   row, column and 1-based order number; tlast marks the final cell of the
//   rectangle. Rows and columns are set by the configuration write port
//   (register 0: row count, register 1: column count, both reset to 8); the
//   user must change them only while no command is in flight; nothing enforces it.
// Timing:
//   A taken command waits in the command register until the result
//   register is free or being drained; its cell then passes through the
//   next-cell logic into the result register, which drives tvalid. While
//   the receiver does not stall, one command per cycle is sustained; the
//   rate is set by the combinational next-cell step.
// Reset and stalls:
//   Reset clears both stages, the position and the order count; the first
//   command after reset yields (0,0). While the receiver stalls, the result
//   is held and one more command is still taken into the command register.
`default_nettype none

module zigzag_scan_address_gen #(
  parameter int unsigned MAX_DIM = zzsag_pkg::MAX_DIM_DEFAULT,
  localparam int unsigned IdxW   = $clog2(MAX_DIM),
  localparam int unsigned CntW   = 2 * IdxW + 1,
  localparam int unsigned OutW   = ((2 * IdxW + CntW + 7) / 8) * 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Slave stream, tdata: restart at bit 0, zeros above.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [zzsag_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Master stream, tdata from bit 0 up: row_index, col_index, order_number.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [OutW-1:0]                     m_axis_tdata,
  output logic                                     m_axis_tlast,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic [zzsag_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [zzsag_pkg::CFG_W-1:0]         cfg_data_i
);
  import zzsag_pkg::*;

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);

  logic [DimW-1:0] rows, cols;

  // Command register.
  logic in_valid_q, in_valid_d;
  logic in_restart_q;

  // Result register, which is also the scan position.
  logic            out_valid_q, out_valid_d;
  logic            started_q;
  logic [IdxW-1:0] cur_row_q, nxt_row;
  logic [IdxW-1:0] cur_col_q, nxt_col;
  logic [CntW-1:0] cur_cnt_q, nxt_cnt;
  logic            last_q, nxt_last;

  logic s_xfer, advance;

  zzsag_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rows_o     (rows),
    .cols_o     (cols)
  );

  zzsag_step #(
    .MAX_DIM (MAX_DIM)
  ) u_step (
    .cur_row_i  (cur_row_q),
    .cur_col_i  (cur_col_q),
    .cur_cnt_i  (cur_cnt_q),
    .started_i  (started_q),
    .restart_i  (in_restart_q),
    .rows_i     (rows),
    .cols_i     (cols),
    .nxt_row_o  (nxt_row),
    .nxt_col_o  (nxt_col),
    .nxt_cnt_o  (nxt_cnt),
    .nxt_last_o (nxt_last)
  );

  // A command moves on when the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cur_cnt_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        started_q <= 1'b1;
        cur_row_q <= nxt_row;
        cur_col_q <= nxt_col;
        cur_cnt_q <= nxt_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_restart_q <= s_axis_tdata[0];
    end
    if (advance) begin
      last_q <= nxt_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = OutW'({cur_cnt_q, cur_col_q, cur_row_q});

  // A result is only ever shown once the scan has produced a cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> started_q)
    else $error("result valid before any cell was produced");

  // The slave side only stalls when both stages are occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // A restart command always lands on the first cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_restart_q) |=>
      ((cur_row_q == '0) && (cur_col_q == '0) && (cur_cnt_q == CntW'(1))))
    else $error("restart did not return to the first cell");

  // Each step either counts on by one or starts over at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=>
      ((cur_cnt_q == CntW'(1)) || (cur_cnt_q == $past(cur_cnt_q) + CntW'(1))))
    else $error("order number skipped");

  // A stalled result keeps its position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=>
      ($stable(cur_row_q) && $stable(cur_col_q) && $stable(cur_cnt_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
